/* hw/rtl/xsr_pkg.sv */
package xsr_pkg;

    localparam int WORD_W  = 32;
    localparam int CNT_W   = 8;
    localparam int DIV_W   = $clog2(WORD_W);
    localparam int ADDR_W  = 3;

    localparam logic [WORD_W-1:0] START_Y = 32'd362436069;
    localparam logic [WORD_W-1:0] START_Z = 32'd521288629;
    localparam logic [WORD_W-1:0] START_W = 32'd88675123;

    localparam int SHIFT_A = 11;
    localparam int SHIFT_B = 19;
    localparam int SHIFT_C = 8;

    localparam logic [CNT_W-1:0] ITER_RESET   = 8'd13;
    localparam logic [CNT_W-1:0] WARMUP_RESET = 8'd17;

    localparam logic OP_RESEED = 1'b0;
    localparam logic OP_DRAW   = 1'b1;

    localparam logic REG_ITER   = 1'b0;
    localparam logic REG_WARMUP = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_WARM = 5'b00010,
        ST_DRAW = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    typedef struct packed {
        logic load_seed;
        logic load_draw;
        logic step;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

/* hw/rtl/xsr_dp.sv */
module xsr_dp
    import xsr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [WORD_W-1:0]   seed_value,
    input  logic [WORD_W-1:0]   range_low,
    input  logic [WORD_W-1:0]   range_high,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2*WORD_W-1:0] m_tdata
);

    logic [WORD_W-1:0] x_reg, y_reg, z_reg, w_reg;
    logic [WORD_W-1:0] x_next, y_next, z_next, w_next;
    logic [WORD_W-1:0] t_val, w_new;

    logic [WORD_W-1:0] lo_reg, lo_next;
    logic [WORD_W-1:0] range_reg, range_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] sh_reg, sh_next;
    logic [WORD_W:0]   r2, diff;

    logic                out_valid_reg, out_valid_next;
    logic [2*WORD_W-1:0] out_data_reg, out_data_next;
    logic [WORD_W-1:0]   bounded;

    assign t_val = x_reg ^ (x_reg << SHIFT_A);
    assign w_new = w_reg ^ (w_reg >> SHIFT_B) ^ t_val ^ (t_val >> SHIFT_C);

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        w_next = w_reg;
        if (cmd.load_seed) begin
            x_next = seed_value;
            y_next = START_Y;
            z_next = START_Z;
            w_next = START_W;
        end else if (cmd.step) begin
            x_next = y_reg;
            y_next = z_reg;
            z_next = w_reg;
            w_next = w_new;
        end
    end

    // restoring remainder, one dividend bit per cycle
    assign r2   = {rem_reg, sh_reg[WORD_W-1]};
    assign diff = r2 - {1'b0, range_reg};

    always_comb begin
        lo_next    = lo_reg;
        range_next = range_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        if (cmd.load_draw) begin
            lo_next    = range_low;
            range_next = range_high - range_low + {{(WORD_W-1){1'b0}}, 1'b1};
        end
        if (cmd.div_load) begin
            rem_next = '0;
            sh_next  = w_new;
        end else if (cmd.div_step) begin
            rem_next = diff[WORD_W] ? r2[WORD_W-1:0] : diff[WORD_W-1:0];
            sh_next  = {sh_reg[WORD_W-2:0], 1'b0};
        end
    end

    // full range wraps to zero: no reduction
    assign bounded = (range_reg == '0) ? (w_reg + lo_reg) : (rem_reg + lo_reg);

    assign sts.out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = {bounded, w_reg};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg         <= '0;
            y_reg         <= START_Y;
            z_reg         <= START_Z;
            w_reg         <= START_W;
            out_valid_reg <= 1'b0;
        end else begin
            x_reg         <= x_next;
            y_reg         <= y_next;
            z_reg         <= z_next;
            w_reg         <= w_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        range_reg    <= range_next;
        rem_reg      <= rem_next;
        sh_reg       <= sh_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hw/rtl/xsr_ctrl.sv */
module xsr_ctrl
    import xsr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             opcode,
    input  logic [CNT_W-1:0] iterations_per_call,
    input  logic [CNT_W-1:0] warmup_calls,
    output cmd_t             cmd,
    input  sts_t             sts
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   iter_reg, iter_next;
    logic [CNT_W-1:0]   call_reg, call_next;
    logic [DIV_W-1:0]   div_cnt_reg, div_cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        call_next    = call_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    iter_next = iterations_per_call;
                    if (opcode == OP_DRAW) begin
                        cmd.load_draw = 1'b1;
                        state_next    = ST_DRAW;
                    end else begin
                        cmd.load_seed = 1'b1;
                        call_next     = warmup_calls;
                        state_next    = ST_WARM;
                    end
                end
            end
            ST_WARM: begin
                if (call_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.step = 1'b1;
                    if (iter_reg == {{(CNT_W-1){1'b0}}, 1'b1}) begin
                        call_next = call_reg - CNT_W'(1);
                        iter_next = iterations_per_call;
                    end else begin
                        iter_next = iter_reg - CNT_W'(1);
                    end
                end
            end
            ST_DRAW: begin
                cmd.step = 1'b1;
                if (iter_reg == {{(CNT_W-1){1'b0}}, 1'b1}) begin
                    cmd.div_load = 1'b1;
                    div_cnt_next = '1;
                    state_next   = ST_DIV;
                end else begin
                    iter_next = iter_reg - CNT_W'(1);
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    div_cnt_next = div_cnt_reg - DIV_W'(1);
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_WARM;
            iter_reg    <= ITER_RESET;
            call_reg    <= WARMUP_RESET;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            call_reg    <= call_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded while output register busy");

    a_step_div_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.step && cmd.div_step))
        else $error("xorshift step during division");

    a_draw_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && opcode == OP_DRAW) |=> (state_reg == ST_DRAW))
        else $error("accepted draw did not start iterations");

    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_DONE) |-> $past(cmd.div_step))
        else $error("result ready without division");

endmodule

/* hw/rtl/xorshift128_bounded_rng.sv */
// xorshift128 random generator with bounded draws.
// s_ channel: one transaction per command. s_tuser = opcode (0 reseed, 1 draw).
//   A reseed loads the start words with the seed as first word and runs
//   warmup_calls calls of iterations_per_call steps; it gives no result.
//   A draw runs one call and returns the fourth word and the bounded value.
// m_ channel: one transaction per draw.
// APB: 0x0 iterations_per_call (0 stores 1), 0x4 warmup_calls; write only when idle.
// Timing: one xorshift step per cycle, then a radix-2 remainder unit at one bit
//   per cycle. For a draw the result is loaded into the output register once the
//   steps and the remainder are done and the output register is free; m_tvalid
//   rises together with s_tready. A reseed returns to idle once its steps are done.
//   One command is in work at a time.
// Reset: registers return to 13 and 17, then a reseed with seed 0 runs with
//   s_tready low until its warm-up steps are done.
// A finished result waits in the output register; new commands are still taken
//   while it waits, and a second result holds until the first is taken.
module xorshift128_bounded_rng
    import xsr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [3*WORD_W-1:0] s_tdata,   // seed_value, range_low, range_high
    input  logic                s_tuser,   // opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2*WORD_W-1:0] m_tdata,   // raw_word, bounded_value
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [CNT_W-1:0] iter_reg, iter_next;
    logic [CNT_W-1:0] warm_reg, warm_next;
    logic             wr_en;
    cmd_t             cmd;
    sts_t             sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        iter_next = iter_reg;
        warm_next = warm_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_ITER: begin
                    iter_next = (pwdata[CNT_W-1:0] == '0) ? {{(CNT_W-1){1'b0}}, 1'b1}
                                                          : pwdata[CNT_W-1:0];
                end
                REG_WARMUP: begin
                    warm_next = pwdata[CNT_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ITER:   prdata = {{(32-CNT_W){1'b0}}, iter_reg};
            REG_WARMUP: prdata = {{(32-CNT_W){1'b0}}, warm_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_reg <= ITER_RESET;
            warm_reg <= WARMUP_RESET;
        end else begin
            iter_reg <= iter_next;
            warm_reg <= warm_next;
        end
    end

    xsr_ctrl u_ctrl (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .opcode              (s_tuser),
        .iterations_per_call (iter_reg),
        .warmup_calls        (warm_reg),
        .cmd                 (cmd),
        .sts                 (sts)
    );

    xsr_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .seed_value (s_tdata[WORD_W-1:0]),
        .range_low  (s_tdata[2*WORD_W-1:WORD_W]),
        .range_high (s_tdata[3*WORD_W-1:2*WORD_W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
